// ----- hdl/bf3_pkg.sv -----
// Package for the 3x3 box mean filter: image geometry, queue sizing,
// divide-by-nine constants and the request types passed between the parts.
// No dependencies.
package bf3_pkg;

  localparam int WIDTH   = 256;
  localparam int HEIGHT  = 256;
  localparam int COL_W   = $clog2(WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT);

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             border;
  } bf3_entry_t;

  typedef struct packed {
    logic       valid;
    bf3_entry_t entry;
  } bf3_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } bf3_q_status_t;

endpackage

// ----- hdl/bf3_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bf3_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/bf3_front.sv -----
// Front end: accepts pixels, tracks raster position, reads and rotates the
// two line stores and pushes window column requests. Uses bf3_pkg, bf3_ram.
module bf3_front
  import bf3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel,
  input  bf3_q_status_t     q_stat,
  output bf3_push_t         push
);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              accept;
  logic [COL_W-1:0]  ocol_next;
  logic [ROW_W-1:0]  orow_next;
  logic              border_next;
  logic [QCNT_W:0]   credit;

  logic              s1_valid;
  logic [COL_W-1:0]  s1_col;
  logic [PIX_W-1:0]  s1_pixel;
  logic [ROW_W-1:0]  s1_orow;
  logic [COL_W-1:0]  s1_ocol;
  logic              s1_border;

  logic [PIX_W-1:0]  near_rd;
  logic [PIX_W-1:0]  far_rd;

  assign credit   = {1'b0, q_stat.count} + (QCNT_W+1)'(s1_valid);
  assign in_stall = credit >= (QCNT_W+1)'(Q_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (col != '0) begin
      ocol_next = col - COL_W'(1);
      orow_next = (row != '0) ? row - ROW_W'(1) : ROW_W'(HEIGHT - 1);
    end else begin
      ocol_next = COL_W'(WIDTH - 1);
      if (row >= ROW_W'(2)) begin
        orow_next = row - ROW_W'(2);
      end else if (row == '0) begin
        orow_next = ROW_W'(HEIGHT - 2);
      end else begin
        orow_next = ROW_W'(HEIGHT - 1);
      end
    end
    border_next = (orow_next == '0) || (orow_next == ROW_W'(HEIGHT - 1)) ||
                  (ocol_next == '0) || (ocol_next == COL_W'(WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col == COL_W'(WIDTH - 1)) begin
          col <= '0;
          row <= (row == ROW_W'(HEIGHT - 1)) ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
    if (accept) begin
      s1_col    <= col;
      s1_pixel  <= pixel;
      s1_orow   <= orow_next;
      s1_ocol   <= ocol_next;
      s1_border <= border_next;
    end
  end

  // row above
  bf3_ram #(.DATA_W(PIX_W), .DEPTH(WIDTH)) u_near (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (s1_pixel),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (near_rd)
  );

  // row two above
  bf3_ram #(.DATA_W(PIX_W), .DEPTH(WIDTH)) u_far (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (near_rd),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (far_rd)
  );

  always_comb begin
    push.valid        = s1_valid;
    push.entry.top    = far_rd;
    push.entry.mid    = near_rd;
    push.entry.bot    = s1_pixel;
    push.entry.orow   = s1_orow;
    push.entry.ocol   = s1_ocol;
    push.entry.border = s1_border;
  end

endmodule

// ----- hdl/bf3_queue.sv -----
// Short request queue between front and back ends.
// Uses bf3_pkg.
module bf3_queue
  import bf3_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  bf3_push_t     push,
  input  logic          pop,
  output bf3_entry_t    head,
  output bf3_q_status_t q_stat
);

  bf3_entry_t        mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

endmodule

// ----- hdl/bf3_back.sv -----
// Back end: 3x3 window, nine-pixel sum, divide by nine, border zeroing and
// output register. Uses bf3_pkg.
module bf3_back
  import bf3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bf3_entry_t        head,
  input  bf3_q_status_t     q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  filtered,
  output logic [7:0]        out_row,
  output logic [7:0]        out_col
);

  logic [PIX_W-1:0] win [6];
  logic             adv;
  logic [SUM_W-1:0] sum_next;

  logic             a_valid;
  logic [SUM_W-1:0] a_sum;
  logic [ROW_W-1:0] a_orow;
  logic [COL_W-1:0] a_ocol;
  logic             a_border;

  logic [SUM_W+RECIP_W-1:0] prod;
  logic [ROW_W+7:0]         row_ext;
  logic [COL_W+7:0]         col_ext;

  assign adv = !out_valid || !out_stall;
  assign pop = !q_stat.empty && (adv || !a_valid);

  assign sum_next = SUM_W'(head.top) + SUM_W'(head.mid) + SUM_W'(head.bot) +
                    SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]) +
                    SUM_W'(win[3]) + SUM_W'(win[4]) + SUM_W'(win[5]);

  assign prod    = (SUM_W+RECIP_W)'(a_sum) * (SUM_W+RECIP_W)'(RECIP9);
  assign row_ext = {8'b0, a_orow};
  assign col_ext = {8'b0, a_ocol};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= a_valid;
        a_valid   <= pop;
      end else if (!a_valid) begin
        a_valid <= pop;
      end
    end
    if (pop) begin
      a_sum    <= sum_next;
      a_orow   <= head.orow;
      a_ocol   <= head.ocol;
      a_border <= head.border;
      win[3]   <= win[0];
      win[4]   <= win[1];
      win[5]   <= win[2];
      win[0]   <= head.top;
      win[1]   <= head.mid;
      win[2]   <= head.bot;
    end
    if (adv && a_valid) begin
      filtered <= a_border ? '0 : prod[RECIP_SHIFT +: PIX_W];
      out_row  <= row_ext[7:0];
      out_col  <= col_ext[7:0];
    end
  end

endmodule

// ----- hdl/box_filter_3x3_stream_unit.sv -----
// 3x3 box mean filter over a raster pixel stream; one result per pixel.
// Throughput: one pixel per clock while in_stall is low, as each accepted pixel reads and writes the line stores.
// in_stall rises only when the four-entry request queue fills under output stall.
// Reset clears position counters and valid bits; line stores are not swept, as their
// contents before the first two rows are written feed only border outputs (forced to 0).
module box_filter_3x3_stream_unit
  import bf3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  filtered,
  output logic [7:0]        out_row,
  output logic [7:0]        out_col
);

  bf3_push_t     push;
  bf3_entry_t    head;
  bf3_q_status_t q_stat;
  logic          pop;

  bf3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel    (pixel),
    .q_stat   (q_stat),
    .push     (push)
  );

  bf3_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  bf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered),
    .out_row   (out_row),
    .out_col   (out_col)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (q_stat.count != QCNT_W'(Q_DEPTH)))
    else $error("request pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("request popped from empty queue");

  a_push_follows_accept: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> $past(in_valid && !in_stall))
    else $error("request pushed without an accepted pixel");
`endif

endmodule

// ----- sim/box_filter_3x3_stream_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for box_filter_3x3_stream_unit: streams pixels over the first rows
// of a frame and checks every filtered result against a line-store model. Depends on bf3_pkg.
module box_filter_3x3_stream_unit_tb;
  import bf3_pkg::*;

  typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_BRIGHT, PAT_DARK, PAT_CHECKER}
    pattern_t;

  class box_mean_scoreboard;
    typedef struct {
      logic [7:0] value;
      logic [7:0] row;
      logic [7:0] col;
    } mean_px_t;

    logic [7:0] rows_above[2*WIDTH];
    logic [7:0] window[6];
    int next_row;
    int next_col;
    mean_px_t expected_q[$];
    int errors;

    function new();
      foreach (rows_above[i]) rows_above[i] = '0;
      foreach (window[i]) window[i] = '0;
      next_row = 0;
      next_col = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    // Window centred one row up and one column left of the accepted pixel.
    function void note_pixel(logic [7:0] px);
      int c;
      int r;
      int orow;
      int ocol;
      int total;
      logic [7:0] mid;
      logic [7:0] top;
      mean_px_t want;
      c = next_col;
      r = next_row;
      mid = rows_above[c];
      top = rows_above[WIDTH + c];
      if (c >= 1) begin
        ocol = c - 1;
        orow = (r >= 1) ? r - 1 : HEIGHT - 1;
      end else begin
        ocol = WIDTH - 1;
        orow = (r >= 2) ? r - 2 : r + HEIGHT - 2;
      end
      want.value = '0;
      if (orow != 0 && orow != HEIGHT - 1 && ocol != 0 && ocol != WIDTH - 1) begin
        total = top + mid + px;
        foreach (window[k]) total += window[k];
        total = total / 9;
        if (total > 255) total = 255;
        want.value = 8'(total);
      end
      want.row = 8'(orow);
      want.col = 8'(ocol);
      expected_q.push_back(want);
      rows_above[WIDTH + c] = mid;
      rows_above[c] = px;
      window[3] = window[0];
      window[4] = window[1];
      window[5] = window[2];
      window[0] = top;
      window[1] = mid;
      window[2] = px;
      c++;
      if (c >= WIDTH) begin
        c = 0;
        r++;
        if (r >= HEIGHT) r = 0;
      end
      next_col = c;
      next_row = r;
    endfunction

    function void check_result(logic [7:0] value, logic [7:0] row, logic [7:0] col);
      mean_px_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual value %0d row %0d col %0d",
                 $time, value, row, col);
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) flag("filtered", want.value, value);
      if (row !== want.row) flag("out_row", want.row, row);
      if (col !== want.col) flag("out_col", want.col, col);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [PIX_W-1:0] pixel;
  logic out_valid;
  logic out_stall;
  logic [PIX_W-1:0] filtered;
  logic [7:0] out_row;
  logic [7:0] out_col;

  box_mean_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int sent;
  pattern_t pattern;

  localparam int QUIET_LIMIT = 2000;

  box_filter_3x3_stream_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered),
    .out_row   (out_row),
    .out_col   (out_col)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(filtered, out_row, out_col);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (in_valid || sb.pending() > 0) begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic send_pixel(input logic [7:0] px);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
    sent++;
  endtask

  // Patterns are drawn anew every 32 pixels so flat, extreme and noisy areas all meet the window.
  function automatic logic [7:0] next_pixel();
    if (sent % 32 == 0) pattern = pattern_t'($urandom_range(0, 5));
    case (pattern)
      PAT_WHITE:   return 8'hFF;
      PAT_BLACK:   return 8'h00;
      PAT_BRIGHT:  return 8'($urandom_range(240, 255));
      PAT_DARK:    return 8'($urandom_range(0, 15));
      PAT_CHECKER: return ((sent + sent / WIDTH) % 2) ? 8'hFF : 8'h00;
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_pixel(next_pixel());
  endtask

  initial begin
    logic [7:0] directed[$];
    directed = {8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
                8'h55, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    pixel = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    sent = 0;
    pattern = PAT_RANDOM;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_pixel(directed[i]);
    run_phase(0, 0, 500);
    run_phase(74, 0, 500);
    run_phase(0, 74, 500);
    run_phase(21, 21, 425);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bf3_pkg.sv
hdl/bf3_ram.sv
hdl/bf3_front.sv
hdl/bf3_queue.sv
hdl/bf3_back.sv
hdl/box_filter_3x3_stream_unit.sv
sim/box_filter_3x3_stream_unit_tb.sv
